// ===== rtl/cfq_pkg.sv =====
// Shared constants, types and the controller state encoding for the circular FIFO queue.
package cfq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned TOTAL_W       = 32;

  // Command codes carried by in_command.
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming word and read the head slot
    logic execute;  // update storage, pointers and counters, load the result
  } dp_cmd_t;

endpackage

// ===== rtl/circular_fifo_queue.sv =====
// Top level of the circular FIFO queue: controller and datapath.
// Each input word is one command, enqueue or dequeue, on a ring buffer of DEPTH signed 32-bit
// words, and each command gives exactly one result word with the success flag, the word read
// (zero unless a dequeue succeeded), the occupancy afterwards and the saturating refusal and
// wrap totals. After acceptance a command reads the head slot from the synchronous slot memory,
// then updates storage and pointers, and then shows its result; a new command is accepted in the
// cycle after the result has been taken, so the block takes no new command while one is in flight.
// Slot contents are not cleared at reset; only words that were enqueued are ever returned.
module circular_fifo_queue #(
  parameter int unsigned DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic signed [cfq_pkg::WORD_W-1:0]  in_write_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_ok,
  output logic signed [cfq_pkg::WORD_W-1:0]  out_read_value,
  output logic [$clog2(DEPTH+1)-1:0]         out_occupancy,
  output logic [cfq_pkg::TOTAL_W-1:0]        out_refusal_count,
  output logic [cfq_pkg::TOTAL_W-1:0]        out_wrap_count
);

  cfq_pkg::dp_cmd_t dp_cmd;

  cfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd)
  );

  cfq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .dp_cmd            (dp_cmd),
    .in_command        (in_command),
    .in_write_value    (in_write_value),
    .out_ok            (out_ok),
    .out_read_value    (out_read_value),
    .out_occupancy     (out_occupancy),
    .out_refusal_count (out_refusal_count),
    .out_wrap_count    (out_wrap_count)
  );

endmodule

// ===== rtl/cfq_ctrl.sv =====
// Controller state machine that sequences one command through capture, execute and delivery.
module cfq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cfq_pkg::dp_cmd_t  dp_cmd
);

  cfq_pkg::state_t state_r;
  cfq_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = cfq_pkg::ST_EXEC;
        end
      end
      cfq_pkg::ST_EXEC: begin
        state_nxt = cfq_pkg::ST_DONE;
      end
      cfq_pkg::ST_DONE: begin
        if (out_ready) begin
          state_nxt = cfq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cfq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready        = (state_r == cfq_pkg::ST_IDLE);
  assign out_valid       = (state_r == cfq_pkg::ST_DONE);
  assign dp_cmd.capture  = in_valid && in_ready;
  assign dp_cmd.execute  = (state_r == cfq_pkg::ST_EXEC);

endmodule

// ===== rtl/cfq_datapath.sv =====
// Datapath: slot memory, head and tail pointers, occupancy, saturating counters and result registers.
module cfq_datapath #(
  parameter int unsigned DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  cfq_pkg::dp_cmd_t                       dp_cmd,
  input  logic                                   in_command,
  input  logic signed [cfq_pkg::WORD_W-1:0]      in_write_value,
  output logic                                   out_ok,
  output logic signed [cfq_pkg::WORD_W-1:0]      out_read_value,
  output logic [$clog2(DEPTH+1)-1:0]             out_occupancy,
  output logic [cfq_pkg::TOTAL_W-1:0]            out_refusal_count,
  output logic [cfq_pkg::TOTAL_W-1:0]            out_wrap_count
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [cfq_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

  logic [cfq_pkg::WORD_W-1:0] mem [DEPTH];

  logic                         cmd_r;
  logic [cfq_pkg::WORD_W-1:0]   wval_r;
  logic [cfq_pkg::WORD_W-1:0]   rdata_r;
  logic [PTR_W-1:0]             head_r, head_nxt;
  logic [PTR_W-1:0]             tail_r, tail_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [cfq_pkg::TOTAL_W-1:0]  refused_r, refused_nxt;
  logic [cfq_pkg::TOTAL_W-1:0]  wraps_r, wraps_nxt;
  logic                         ok_nxt;
  logic [cfq_pkg::WORD_W-1:0]   rval_nxt;
  logic                         do_write;

  logic                         ok_r;
  logic [cfq_pkg::WORD_W-1:0]   rval_r;

  // The head slot is read while the word is captured, so its data is ready for execute.
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_r   <= in_command;
      wval_r  <= in_write_value;
      rdata_r <= mem[head_r];
    end
    if (do_write) begin
      mem[tail_r] <= wval_r;
    end
  end

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    refused_nxt = refused_r;
    wraps_nxt   = wraps_r;
    ok_nxt      = 1'b0;
    rval_nxt    = '0;
    do_write    = 1'b0;
    if (dp_cmd.execute) begin
      if (cmd_r == cfq_pkg::CMD_ENQUEUE) begin
        if (count_r == CNT_FULL) begin
          if (refused_r != TOTAL_MAX) begin
            refused_nxt = refused_r + 1'b1;
          end
        end else begin
          do_write  = 1'b1;
          ok_nxt    = 1'b1;
          count_nxt = count_r + 1'b1;
          if (tail_r == PTR_LAST) begin
            tail_nxt = '0;
            if (wraps_r != TOTAL_MAX) begin
              wraps_nxt = wraps_r + 1'b1;
            end
          end else begin
            tail_nxt = tail_r + 1'b1;
          end
        end
      end else begin
        if (count_r != '0) begin
          ok_nxt    = 1'b1;
          rval_nxt  = rdata_r;
          count_nxt = count_r - 1'b1;
          head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      refused_r <= '0;
      wraps_r   <= '0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      refused_r <= refused_nxt;
      wraps_r   <= wraps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.execute) begin
      ok_r   <= ok_nxt;
      rval_r <= rval_nxt;
    end
  end

  assign out_ok            = ok_r;
  assign out_read_value    = rval_r;
  assign out_occupancy     = count_r;
  assign out_refusal_count = refused_r;
  assign out_wrap_count    = wraps_r;

endmodule

// ===== rtl/cfq_checker.sv =====
// Port-level checker for the circular FIFO queue, bound to the top level.
module cfq_checker #(
  parameter int unsigned DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_ok,
  input logic signed [cfq_pkg::WORD_W-1:0]  out_read_value,
  input logic [$clog2(DEPTH+1)-1:0]         out_occupancy,
  input logic [cfq_pkg::TOTAL_W-1:0]        out_refusal_count,
  input logic [cfq_pkg::TOTAL_W-1:0]        out_wrap_count
);

  // A waiting result word must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value) && $stable(out_ok))
    else $error("result word changed while stalled");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= ($clog2(DEPTH+1))'(DEPTH))
    else $error("occupancy above depth");

  // A failed command never returns data.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_read_value == '0)
    else $error("failed command returned a non-zero word");

  // The totals only ever grow between consecutive results.
  a_totals_grow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(rst_n) |-> out_refusal_count >= $past(out_refusal_count)
                                  && out_wrap_count >= $past(out_wrap_count))
    else $error("a saturating total went down");

  // A command is never accepted while a result is still on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && out_valid))
    else $error("command accepted while a result was pending");

endmodule

bind circular_fifo_queue cfq_checker #(.DEPTH(DEPTH)) u_cfq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_ok            (out_ok),
  .out_read_value    (out_read_value),
  .out_occupancy     (out_occupancy),
  .out_refusal_count (out_refusal_count),
  .out_wrap_count    (out_wrap_count)
);

// ===== sim/circular_fifo_queue_checker.sv =====
// Checker for the circular FIFO queue: predicts each result word and compares it with the block.
module circular_fifo_queue_checker #(
  parameter int unsigned DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_command,
  input  logic signed [cfq_pkg::WORD_W-1:0]   in_write_value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                out_ok,
  input  logic signed [cfq_pkg::WORD_W-1:0]   out_read_value,
  input  logic [$clog2(DEPTH+1)-1:0]          out_occupancy,
  input  logic [cfq_pkg::TOTAL_W-1:0]         out_refusal_count,
  input  logic [cfq_pkg::TOTAL_W-1:0]         out_wrap_count,
  output int                                  mismatches,
  output int                                  awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);

  typedef struct {
    logic                              ok;
    logic signed [cfq_pkg::WORD_W-1:0] read_value;
    logic [OCC_W-1:0]                  occupancy;
    logic [cfq_pkg::TOTAL_W-1:0]       refusals;
    logic [cfq_pkg::TOTAL_W-1:0]       wraps;
  } queue_reply_t;

  logic signed [cfq_pkg::WORD_W-1:0] slot_mem [DEPTH];
  logic [PTR_W-1:0]                  rd_ptr;
  logic [PTR_W-1:0]                  wr_ptr;
  logic [OCC_W-1:0]                  fill;
  logic [cfq_pkg::TOTAL_W-1:0]       refused;
  logic [cfq_pkg::TOTAL_W-1:0]       wrapped;
  queue_reply_t                      pending_replies [$];
  int                                err_count = 0;

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [cfq_pkg::TOTAL_W-1:0] sat_up(logic [cfq_pkg::TOTAL_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // Applies one command to the shadow queue and returns the word the block should give.
  function automatic queue_reply_t apply_command(logic cmd,
                                                 logic signed [cfq_pkg::WORD_W-1:0] val);
    queue_reply_t r;
    r.ok         = 1'b0;
    r.read_value = '0;
    if (cmd == cfq_pkg::CMD_ENQUEUE) begin
      if (fill == OCC_W'(DEPTH)) begin
        refused = sat_up(refused);
      end else begin
        slot_mem[wr_ptr] = val;
        wr_ptr = next_ptr(wr_ptr);
        if (wr_ptr == '0) wrapped = sat_up(wrapped);
        fill = fill + 1'b1;
        r.ok = 1'b1;
      end
    end else if (fill != '0) begin
      r.read_value = slot_mem[rd_ptr];
      rd_ptr = next_ptr(rd_ptr);
      fill = fill - 1'b1;
      r.ok = 1'b1;
    end
    r.occupancy = fill;
    r.refusals  = refused;
    r.wraps     = wrapped;
    return r;
  endfunction

  task automatic check_field(string field, logic [cfq_pkg::TOTAL_W-1:0] want,
                             logic [cfq_pkg::TOTAL_W-1:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    end
  endtask

  always @(posedge clk) begin : tracker
    queue_reply_t want;
    if (!rst_n) begin
      rd_ptr  = '0;
      wr_ptr  = '0;
      fill    = '0;
      refused = '0;
      wrapped = '0;
      pending_replies.delete();
    end else begin
      // A command word accepted on this edge is always younger than any result taken on it.
      if (in_valid && in_ready)
        pending_replies.push_back(apply_command(in_command, in_write_value));
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: result word with no command outstanding", $realtime);
        end else begin
          want = pending_replies.pop_front();
          check_field("ok", cfq_pkg::TOTAL_W'(want.ok), cfq_pkg::TOTAL_W'(out_ok));
          check_field("read_value", cfq_pkg::TOTAL_W'(want.read_value),
                      cfq_pkg::TOTAL_W'(out_read_value));
          check_field("occupancy", cfq_pkg::TOTAL_W'(want.occupancy),
                      cfq_pkg::TOTAL_W'(out_occupancy));
          check_field("refusal_count", want.refusals, out_refusal_count);
          check_field("wrap_count", want.wraps, out_wrap_count);
        end
      end
    end
    mismatches <= err_count;
    awaiting   <= pending_replies.size();
  end

endmodule

// ===== sim/circular_fifo_queue_test.sv =====
// Top of the circular FIFO queue testbench: clock, reset, command stimulus and verdict.
module circular_fifo_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = cfq_pkg::DEPTH_DEFAULT;
  localparam int unsigned OCC_W       = $clog2(DEPTH + 1);
  localparam int          RANDOM_CMDS = 750;
  localparam int          STALL_LIMIT = 200;
  localparam int          DRAIN_CYCLES = 10;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic                              in_command;
  logic signed [cfq_pkg::WORD_W-1:0] in_write_value;
  logic                              out_valid;
  logic                              out_ready;
  logic                              out_ok;
  logic signed [cfq_pkg::WORD_W-1:0] out_read_value;
  logic [OCC_W-1:0]                  out_occupancy;
  logic [cfq_pkg::TOTAL_W-1:0]       out_refusal_count;
  logic [cfq_pkg::TOTAL_W-1:0]       out_wrap_count;
  int                                mismatches;
  int                                awaiting;

  circular_fifo_queue #(.DEPTH(DEPTH)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_write_value    (in_write_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ok            (out_ok),
    .out_read_value    (out_read_value),
    .out_occupancy     (out_occupancy),
    .out_refusal_count (out_refusal_count),
    .out_wrap_count    (out_wrap_count)
  );

  circular_fifo_queue_checker #(.DEPTH(DEPTH)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_write_value    (in_write_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ok            (out_ok),
    .out_read_value    (out_read_value),
    .out_occupancy     (out_occupancy),
    .out_refusal_count (out_refusal_count),
    .out_wrap_count    (out_wrap_count),
    .mismatches        (mismatches),
    .awaiting          (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [cfq_pkg::WORD_W-1:0] corner_word(int unsigned k);
    case (k)
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h5555_5555;
      default: return 32'hAAAA_AAAA;
    endcase
  endfunction

  // Offers one command word and returns on the edge at which it is taken.
  task automatic send_word(logic cmd, logic [cfq_pkg::WORD_W-1:0] val);
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_write_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_for(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Holds the sender off until every outstanding result word has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  initial begin : stimulus
    int                         burst_left;
    int                         mode_left;
    int unsigned                enq_pct;
    logic                       cmd;
    logic [cfq_pkg::WORD_W-1:0] word;
    burst_left     = 0;
    mode_left      = 0;
    enq_pct        = 50;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= cfq_pkg::CMD_ENQUEUE;
    in_write_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty dequeue, a fill to the brim that wraps the tail, refusals, then reads of the corners.
    send_word(cfq_pkg::CMD_DEQUEUE, $urandom());
    for (int i = 0; i < DEPTH; i++)
      send_word(cfq_pkg::CMD_ENQUEUE, (i < 6) ? corner_word(i) : $urandom());
    send_word(cfq_pkg::CMD_ENQUEUE, $urandom());
    send_word(cfq_pkg::CMD_ENQUEUE, corner_word(3));
    repeat (4) send_word(cfq_pkg::CMD_DEQUEUE, $urandom());
    drain_results();

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      // Spells biased towards enqueue or dequeue drive the queue to full and back to empty.
      if (mode_left == 0) begin
        case ($urandom_range(2))
          0:       enq_pct = 85;
          1:       enq_pct = 50;
          default: enq_pct = 15;
        endcase
        mode_left = $urandom_range(8, 40);
      end
      if (burst_left == 0) begin
        idle_for($urandom_range(1, 8));
        burst_left = $urandom_range(1, 24);
      end
      if (i == RANDOM_CMDS / 2) drain_results();
      cmd  = ($urandom_range(99) < enq_pct) ? cfq_pkg::CMD_ENQUEUE : cfq_pkg::CMD_DEQUEUE;
      word = ($urandom_range(9) == 0) ? corner_word($urandom_range(5)) : $urandom();
      send_word(cmd, word);
      burst_left--;
      mode_left--;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaiting == 0)
      $display("circular_fifo_queue_test passed");
    else
      $display("circular_fifo_queue_test failed");
    $finish;
  end

  // The receiver alternates ready stretches with stalls, some stretches having no stall at all.
  initial begin : sink_pattern
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 20)) @(posedge clk);
      if ($urandom_range(3) != 0) begin
        @(posedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("circular_fifo_queue_test failed");
    $finish;
  end

endmodule
